FILE: rtl/bmprle_pkg.sv
// Shared types and constants for the BMP RLE8/RLE4 gray decoder.
// No dependencies; the top, palette and parser files refer to it by scoped names.
package bmprle_pkg;

  localparam int MAX_DIM      = 4096;
  localparam int DIM_W        = $clog2(MAX_DIM) + 1;
  localparam int POS_W        = 12;
  localparam int PAL_SIZE     = 256;
  localparam int PAL_AW       = $clog2(PAL_SIZE);

  typedef enum logic [1:0] {
    REQ_PAL   = 2'd0,
    REQ_DATA  = 2'd1,
    REQ_START = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    CFG_MODE   = 2'd0,
    CFG_WIDTH  = 2'd1,
    CFG_HEIGHT = 2'd2,
    CFG_SPARE  = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    PH_COUNT   = 3'd0,
    PH_VALUE   = 3'd1,
    PH_ESCAPE  = 3'd2,
    PH_LITERAL = 3'd3,
    PH_PAD     = 3'd4
  } phase_t;

  typedef struct packed {
    logic [POS_W-1:0] col;
    logic [POS_W-1:0] row;
    logic [7:0]       count;
    logic             eoi;
    logic             clip;
  } run_t;

endpackage

FILE: rtl/bmp_rle_gray_decoder_top.sv
// Top level of the BMP RLE8/RLE4 gray decoder: stream ports, palette,
// parser and output register. Depends on bmprle_pkg, bmprle_palette, bmprle_parser.
//
// Takes one beat per cycle on the slave side while no result is stalled: palette loads
// (tuser 0), compressed data bytes (tuser 1) and start-of-image beats (tuser 2). Each
// run, literal data byte and end or delta escape yields one beat on the master side via
// the parser result and output registers; one beat per cycle while m_tready is high, set
// by the parser update and registered palette read. The 256-entry gray palette must be
// loaded before data bytes refer to it. end_of_image travels as m_tlast. Configuration
// (index 0 mode, 1 width, 2 height) is the user's to write while idle; not enforced.
module bmp_rle_gray_decoder_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,  // data_byte, pal_index, pal_color
  input  logic [1:0]  s_tuser,  // req_type
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,  // gray_first, gray_second, col, row, pixel_count, clipped
  output logic        m_tlast   // end_of_image
);

  logic             accept, take, rle4, res_valid;
  bmprle_pkg::run_t res;
  logic [7:0]       gray_a, gray_b;
  logic [7:0]       data_byte;
  logic [bmprle_pkg::PAL_AW-1:0] raddr_a, raddr_b;

  assign data_byte = s_tdata[7:0];
  assign take      = res_valid && (!m_tvalid || m_tready);
  assign s_tready  = !res_valid || take;
  assign accept    = s_tvalid && s_tready;
  assign raddr_a   = rle4 ? {4'd0, data_byte[7:4]} : data_byte;
  assign raddr_b   = rle4 ? {4'd0, data_byte[3:0]} : data_byte;

  bmprle_palette u_palette (
    .clk     (clk),
    .we      (accept && s_tuser == bmprle_pkg::REQ_PAL),
    .waddr   (s_tdata[15:8]),
    .color   (s_tdata[39:16]),
    .re      (accept),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (gray_a),
    .rdata_b (gray_b)
  );

  bmprle_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .req_type  (s_tuser),
    .data_byte (data_byte),
    .take      (take),
    .rle4      (rle4),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (take) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      m_tdata <= {7'd0, res.clip, res.count, res.row, res.col,
                  res.eoi ? 8'd0 : gray_b, res.eoi ? 8'd0 : gray_a};
      m_tlast <= res.eoi;
    end
  end

endmodule

FILE: rtl/bmprle_palette.sv
// Gray palette: colour to gray conversion on load, 256x8 memory with two
// registered read ports. Depends on bmprle_pkg.
module bmprle_palette (
  input  logic                           clk,
  input  logic                           we,
  input  logic [bmprle_pkg::PAL_AW-1:0]  waddr,
  input  logic [23:0]                    color,
  input  logic                           re,
  input  logic [bmprle_pkg::PAL_AW-1:0]  raddr_a,
  input  logic [bmprle_pkg::PAL_AW-1:0]  raddr_b,
  output logic [7:0]                     rdata_a,
  output logic [7:0]                     rdata_b
);

  logic [7:0] mem [bmprle_pkg::PAL_SIZE];
  logic [9:0] sum;

  assign sum = {2'b00, color[7:0]} + {1'b0, color[15:8], 1'b0} + {2'b00, color[23:16]};

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= sum[9:2];
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

FILE: rtl/bmprle_parser.sv
// Configuration registers, RLE byte parser and position tracking; holds one
// decoded run until the output stage takes it. Depends on bmprle_pkg.
module bmprle_parser (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [bmprle_pkg::DIM_W-1:0]  cfg_data,
  input  logic                          accept,
  input  logic [1:0]                    req_type,
  input  logic [7:0]                    data_byte,
  input  logic                          take,
  output logic                          rle4,
  output logic                          res_valid,
  output bmprle_pkg::run_t              res
);

  localparam int DW = bmprle_pkg::DIM_W;

  logic [DW-1:0]         image_width;
  logic [DW-1:0]         image_height;
  bmprle_pkg::phase_t    phase, phase_next;
  logic [7:0]            held_count, held_count_next;
  logic [7:0]            literal_left, literal_left_next;
  logic                  pad_pending, pad_pending_next;
  logic [DW-1:0]         cur_col, cur_col_next;
  logic [DW-1:0]         cur_row, cur_row_next;
  logic                  image_done, image_done_next;

  logic [DW-1:0]         w, h, avail;
  logic [7:0]            n, k;
  logic                  emit, eoi, has_res;
  logic [8:0]            b_inc;

  always_ff @(posedge clk) begin
    if (rst) begin
      rle4         <= 1'b0;
      image_width  <= DW'(256);
      image_height <= DW'(256);
    end else if (cfg_we) begin
      unique case (bmprle_pkg::cfg_idx_t'(cfg_index))
        bmprle_pkg::CFG_MODE:   rle4 <= cfg_data[0];
        bmprle_pkg::CFG_WIDTH:  image_width <= cfg_data;
        bmprle_pkg::CFG_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (image_width == '0) w = DW'(1);
    else if (image_width > DW'(bmprle_pkg::MAX_DIM)) w = DW'(bmprle_pkg::MAX_DIM);
    else w = image_width;
    if (image_height == '0) h = DW'(1);
    else if (image_height > DW'(bmprle_pkg::MAX_DIM)) h = DW'(bmprle_pkg::MAX_DIM);
    else h = image_height;
  end

  assign b_inc = {1'b0, data_byte} + 9'd1;

  always_comb begin
    phase_next        = phase;
    held_count_next   = held_count;
    literal_left_next = literal_left;
    pad_pending_next  = pad_pending;
    cur_row_next      = cur_row;
    image_done_next   = image_done;
    emit              = 1'b0;
    eoi               = 1'b0;
    n                 = held_count;
    if (req_type == bmprle_pkg::REQ_START) begin
      phase_next        = bmprle_pkg::PH_COUNT;
      held_count_next   = '0;
      literal_left_next = '0;
      pad_pending_next  = 1'b0;
      cur_row_next      = '0;
      image_done_next   = 1'b0;
    end else if (req_type == bmprle_pkg::REQ_DATA && !image_done) begin
      unique case (phase)
        bmprle_pkg::PH_COUNT: begin
          if (data_byte == 8'd0) begin
            phase_next = bmprle_pkg::PH_ESCAPE;
          end else begin
            held_count_next = data_byte;
            phase_next      = bmprle_pkg::PH_VALUE;
          end
        end
        bmprle_pkg::PH_VALUE: begin
          phase_next = bmprle_pkg::PH_COUNT;
          emit       = 1'b1;
          n          = held_count;
        end
        bmprle_pkg::PH_ESCAPE: begin
          phase_next = bmprle_pkg::PH_COUNT;
          if (data_byte == 8'd0) begin
            if (cur_row < h) cur_row_next = cur_row + DW'(1);
          end else if (data_byte == 8'd1 || data_byte == 8'd2) begin
            image_done_next = 1'b1;
            eoi             = 1'b1;
          end else begin
            literal_left_next = data_byte;
            pad_pending_next  = rle4 ? b_inc[1] : data_byte[0];
            phase_next        = bmprle_pkg::PH_LITERAL;
          end
        end
        bmprle_pkg::PH_LITERAL: begin
          emit = 1'b1;
          if (rle4) n = (literal_left < 8'd2) ? literal_left : 8'd2;
          else      n = (literal_left < 8'd1) ? literal_left : 8'd1;
          literal_left_next = literal_left - n;
          if (literal_left_next == 8'd0) begin
            phase_next       = pad_pending ? bmprle_pkg::PH_PAD : bmprle_pkg::PH_COUNT;
            pad_pending_next = 1'b0;
          end
        end
        default: phase_next = bmprle_pkg::PH_COUNT;
      endcase
    end
  end

  always_comb begin
    avail = (cur_row < h && cur_col < w) ? (w - cur_col) : '0;
    k     = ({{(DW-8){1'b0}}, n} < avail) ? n : avail[7:0];
    has_res = emit || eoi;
    if (req_type == bmprle_pkg::REQ_START) cur_col_next = '0;
    else if (req_type == bmprle_pkg::REQ_DATA && !image_done && phase == bmprle_pkg::PH_ESCAPE
             && data_byte == 8'd0) cur_col_next = '0;
    else if (emit) cur_col_next = cur_col + {{(DW-8){1'b0}}, k};
    else cur_col_next = cur_col;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= bmprle_pkg::PH_COUNT;
      held_count   <= '0;
      literal_left <= '0;
      pad_pending  <= 1'b0;
      cur_col      <= '0;
      cur_row      <= '0;
      image_done   <= 1'b0;
      res_valid    <= 1'b0;
    end else if (accept) begin
      phase        <= phase_next;
      held_count   <= held_count_next;
      literal_left <= literal_left_next;
      pad_pending  <= pad_pending_next;
      cur_col      <= cur_col_next;
      cur_row      <= cur_row_next;
      image_done   <= image_done_next;
      res_valid    <= has_res;
    end else if (take) begin
      res_valid    <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res.col   <= cur_col[DW-1] ? '1 : cur_col[bmprle_pkg::POS_W-1:0];
      res.row   <= cur_row[DW-1] ? '1 : cur_row[bmprle_pkg::POS_W-1:0];
      res.count <= eoi ? 8'd0 : k;
      res.eoi   <= eoi;
      res.clip  <= eoi ? 1'b0 : ({{(DW-8){1'b0}}, n} > avail);
    end
  end

endmodule

FILE: rtl/bmprle_checker.sv
// Port-level checks for the BMP RLE gray decoder, bound to the top level.
// Depends on bmp_rle_gray_decoder_top.
module bmprle_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [55:0] m_tdata,
  input logic        m_tlast
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output beat changed while stalled");

  a_rst_idle: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  a_end_beat: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tdata[15:0] == 16'd0 && m_tdata[47:40] == 8'd0
                            && !m_tdata[48])
    else $error("end beat carries pixels");

  a_empty_run: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast && m_tdata[47:40] == 8'd0 |-> m_tdata[48])
    else $error("empty run without clip flag");

endmodule

bind bmp_rle_gray_decoder_top bmprle_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
